// ===== hw/rtl/audec_pkg.sv =====
// Shared constants and types for the block audio decoder.
`timescale 1ns / 1ps

package audec_pkg;

	localparam int BYTE_W    = 8;
	localparam int SAMPLE_W  = 16;
	localparam int INDEX_W   = 6;
	localparam int HDR_DEPTH = 16;
	localparam int HDR_AW    = $clog2(HDR_DEPTH);
	localparam int POS_W     = 5;
	localparam int CODE_W    = 10;

	localparam logic [HDR_AW-1:0] LOW_BASE  = 4'd6;
	localparam logic [HDR_AW-1:0] HIGH_BASE = 4'd11;

	localparam logic [CODE_W-1:0] CODE5_MASK  = 10'h01F;
	localparam logic [CODE_W-1:0] CODE10_MASK = 10'h3FF;

	localparam logic signed [28:0] HALF_FMT0 = 29'sd16;
	localparam logic signed [28:0] HALF_FMT1 = 29'sd512;

	localparam logic FMT_GROUPS_OF_8  = 1'b0;
	localparam logic FMT_GROUPS_OF_16 = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_MUL_LO,
		S_MUL_HI,
		S_FIN,
		S_SPAN,
		S_OUT
	} state_t;

endpackage

// ===== hw/rtl/audec_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module audec_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/block_audio_decoder.sv =====
// Top level of the block audio decoder: header memory, endpoint scaling and sample output.
`timescale 1ns / 1ps

// Channel   Direction  Signals                                         Item
// code      in         code_valid, code_ready, code_byte               one block byte
// sample    out        sample_valid, sample_ready, sample,             one decoded sample
//                      sample_index, last_of_byte, block_end
// cfg       in         cfg_valid, cfg_ready, block_format              format register write
//
// A header byte (positions 0 to 15) is written to the header memory when it is accepted.
// An index byte takes four reads through the one read port of the header memory, two passes
// through the shared multiplier, and four samples, one per cycle when the output is not
// stalled, through the output register, before the next byte is accepted.
// A stalled output holds the sample sequence; the last sample may wait while a new byte enters.
// Reset clears the byte position, the format register and the output valid flag.

module block_audio_decoder (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  code_valid,
	output logic                                  code_ready,
	input  logic [audec_pkg::BYTE_W-1:0]          code_byte,
	output logic                                  sample_valid,
	input  logic                                  sample_ready,
	output logic signed [audec_pkg::SAMPLE_W-1:0] sample,
	output logic [audec_pkg::INDEX_W-1:0]         sample_index,
	output logic                                  last_of_byte,
	output logic                                  block_end,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic                                  block_format
);

	import audec_pkg::*;

	function automatic logic [CODE_W-1:0] extract_code(
		input logic [BYTE_W-1:0] lo_b,
		input logic [BYTE_W-1:0] hi_b,
		input logic [2:0]        shamt,
		input logic              fmt
	);
		logic [2*BYTE_W-1:0] word;
		word = {hi_b, lo_b} >> shamt;
		return (fmt == FMT_GROUPS_OF_16) ? (word[CODE_W-1:0] & CODE10_MASK)
			: (word[CODE_W-1:0] & CODE5_MASK);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] clamp16(
		input logic signed [29:0]         v,
		input logic signed [SAMPLE_W-1:0] lo,
		input logic signed [SAMPLE_W-1:0] hi
	);
		logic signed [SAMPLE_W-1:0] r;
		if (v < 30'(lo)) begin
			r = lo;
		end else if (v < 30'(hi)) begin
			r = v[SAMPLE_W-1:0];
		end else begin
			r = hi;
		end
		return r;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] scale_code(
		input logic signed [27:0]         prod,
		input logic                       fmt,
		input logic signed [SAMPLE_W-1:0] cm,
		input logic signed [SAMPLE_W-1:0] cn
	);
		logic signed [28:0] sum;
		logic signed [28:0] sh;
		logic signed [29:0] p;
		sum = (fmt == FMT_GROUPS_OF_16) ? (29'(prod) + HALF_FMT1) : (29'(prod) + HALF_FMT0);
		sh  = (fmt == FMT_GROUPS_OF_16) ? (sum >>> 10) : (sum >>> 5);
		p   = 30'(sh) + 30'(cm);
		return clamp16(p, cm, cn);
	endfunction

	state_t state_q, state_d;

	logic [POS_W-1:0]  pos_q;
	logic              format_q;
	logic [2:0]        cnt_q;
	logic              ram_we;
	logic [HDR_AW-1:0] ram_raddr;
	logic [BYTE_W-1:0] ram_rdata;
	logic              out_load;
	logic              accept;

	logic signed [SAMPLE_W-1:0] min_q, max_q;
	logic [BYTE_W-1:0]          byte_q;
	logic [3:0]                 bidx_q;
	logic                       fmt_q;
	logic [5:0]                 off_q;
	logic signed [SAMPLE_W:0]   span_q;
	logic [BYTE_W-1:0]          cb_q [4];
	logic signed [27:0]         prod_s1;
	logic signed [SAMPLE_W-1:0] glo_q, ghi_q;
	logic signed [SAMPLE_W:0]   sp2_q;

	logic [CODE_W-1:0]        code_sel;
	logic [1:0]               idx_sel;
	logic signed [18:0]       interp_t;
	logic signed [19:0]       interp_v;
	logic signed [SAMPLE_W-1:0] interp_s;
	logic [5:0]               off_d;
	logic [3:0]               bidx_d;
	logic [HDR_AW-1:0]        b_ext;

	logic signed [SAMPLE_W-1:0] sample_q;
	logic [INDEX_W-1:0]         sample_index_q;
	logic                       last_q, end_q, sample_valid_q;

	assign cfg_ready = 1'b1;
	assign accept    = code_valid && code_ready;

	always_comb begin
		state_d    = state_q;
		code_ready = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				code_ready = 1'b1;
				if (code_valid && pos_q[POS_W-1]) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				if (cnt_q == 3'd4) begin
					state_d = S_MUL_LO;
				end
			end
			S_MUL_LO: state_d = S_MUL_HI;
			S_MUL_HI: state_d = S_FIN;
			S_FIN:    state_d = S_SPAN;
			S_SPAN:   state_d = S_OUT;
			S_OUT: begin
				out_load = !sample_valid_q || sample_ready;
				if (out_load && cnt_q[1:0] == 2'd3) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			pos_q          <= '0;
			format_q       <= FMT_GROUPS_OF_8;
			cnt_q          <= '0;
			sample_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				format_q <= block_format;
			end
			if (accept) begin
				pos_q <= pos_q + 5'd1;
				cnt_q <= '0;
			end else if (state_q == S_READ) begin
				cnt_q <= (cnt_q == 3'd4) ? 3'd0 : cnt_q + 3'd1;
			end else if (out_load) begin
				cnt_q <= cnt_q + 3'd1;
			end
			if (out_load) begin
				sample_valid_q <= 1'b1;
			end else if (sample_ready) begin
				sample_valid_q <= 1'b0;
			end
		end
	end

	assign ram_we = accept && !pos_q[POS_W-1];

	audec_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(HDR_DEPTH)
	) u_hdr_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(pos_q[HDR_AW-1:0]),
		.wdata(code_byte),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign bidx_d = pos_q[3:0];
	always_comb begin
		if (format_q == FMT_GROUPS_OF_16) begin
			off_d = {1'b0, bidx_d[3:2], 3'b000} + {2'b00, bidx_d[3:2], 1'b0};
		end else begin
			off_d = {1'b0, bidx_d[3:1], 2'b00} + {3'b000, bidx_d[3:1]};
		end
	end

	assign b_ext = {1'b0, off_q[5:3]};
	always_comb begin
		unique case (cnt_q[1:0])
			2'd0: ram_raddr = LOW_BASE + b_ext;
			2'd1: ram_raddr = LOW_BASE + b_ext + 4'd1;
			2'd2: ram_raddr = HIGH_BASE + b_ext;
			2'd3: ram_raddr = HIGH_BASE + b_ext + 4'd1;
			default: ram_raddr = LOW_BASE;
		endcase
	end

	assign code_sel = (state_q == S_MUL_LO) ? extract_code(cb_q[0], cb_q[1], off_q[2:0], fmt_q)
		: extract_code(cb_q[2], cb_q[3], off_q[2:0], fmt_q);

	always_comb begin
		unique case (cnt_q[1:0])
			2'd0: idx_sel = byte_q[1:0];
			2'd1: idx_sel = byte_q[3:2];
			2'd2: idx_sel = byte_q[5:4];
			2'd3: idx_sel = byte_q[7:6];
			default: idx_sel = byte_q[1:0];
		endcase
	end

	always_comb begin
		unique case (idx_sel)
			2'd0: interp_t = '0;
			2'd1: interp_t = 19'(sp2_q);
			2'd2: interp_t = 19'(sp2_q) <<< 1;
			2'd3: interp_t = 19'(sp2_q) + (19'(sp2_q) <<< 1);
			default: interp_t = '0;
		endcase
		interp_v = ((20'(interp_t) + 20'sd1) >>> 2) + 20'(glo_q);
		interp_s = clamp16(30'(interp_v), glo_q, ghi_q);
	end

	always_ff @(posedge clk) begin
		if (ram_we && pos_q[3:0] == 4'd0) begin
			min_q[7:0] <= code_byte;
		end
		if (ram_we && pos_q[3:0] == 4'd1) begin
			min_q[15:8] <= code_byte;
		end
		if (ram_we && pos_q[3:0] == 4'd2) begin
			max_q[7:0] <= code_byte;
		end
		if (ram_we && pos_q[3:0] == 4'd3) begin
			max_q[15:8] <= code_byte;
		end
		if (accept && pos_q[POS_W-1]) begin
			byte_q <= code_byte;
			bidx_q <= bidx_d;
			fmt_q  <= format_q;
			off_q  <= off_d;
			span_q <= 17'(max_q) - 17'(min_q);
		end
		if (state_q == S_READ && cnt_q != 3'd0) begin
			cb_q[2'(cnt_q - 3'd1)] <= ram_rdata;
		end
		prod_s1 <= 28'(span_q) * $signed({1'b0, code_sel});
		if (state_q == S_MUL_HI) begin
			glo_q <= scale_code(prod_s1, fmt_q, min_q, max_q);
		end
		if (state_q == S_FIN) begin
			ghi_q <= scale_code(prod_s1, fmt_q, min_q, max_q);
		end
		if (state_q == S_SPAN) begin
			sp2_q <= 17'(ghi_q) - 17'(glo_q);
		end
		if (out_load) begin
			sample_q       <= interp_s;
			sample_index_q <= {bidx_q, cnt_q[1:0]};
			last_q         <= (cnt_q[1:0] == 2'd3);
			end_q          <= (bidx_q == 4'hF) && (cnt_q[1:0] == 2'd3);
		end
	end

	assign sample_valid = sample_valid_q;
	assign sample       = sample_q;
	assign sample_index = sample_index_q;
	assign last_of_byte = last_q;
	assign block_end    = end_q;

endmodule

// ===== hw/rtl/audec_checker.sv =====
// Port-level assertions for the block audio decoder, bound to the top level.
`timescale 1ns / 1ps

module audec_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        code_ready,
	input logic        sample_valid,
	input logic        sample_ready,
	input logic [15:0] sample,
	input logic [5:0]  sample_index,
	input logic        last_of_byte,
	input logic        block_end
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_ready |=> sample_valid && $stable(sample)
			&& $stable(sample_index))
		else $error("Stalled sample item changed.");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid |-> last_of_byte == (sample_index[1:0] == 2'd3))
		else $error("Last-of-byte flag does not match the sample position.");

	a_end_flag: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid |-> block_end == (sample_index == 6'd63))
		else $error("Block-end flag does not match the sample position.");

	a_next_sample: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready && !last_of_byte
			|=> sample_valid && sample_index == $past(sample_index) + 6'd1)
		else $error("Samples of one byte did not follow in order.");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !last_of_byte |-> !code_ready)
		else $error("Input accepted while a byte still had samples to deliver.");

endmodule

bind block_audio_decoder audec_checker u_audec_checker (.*);
